// ===== rtl/pdh_pkg.sv =====
// Package for the periodic pair distance histogram.
// Holds the payload structs, configuration and control types and sizing constants.
// No dependencies.
package pdh_pkg;

    // Histogram sizing.
    localparam int NUM_BINS    = 64;
    localparam int BIN_IDX_W   = $clog2(NUM_BINS);
    localparam int USED_W      = 7;
    localparam int COUNT_WIDTH = 32;

    // Iteration counts of the shared divider and of the square root unit.
    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 32;
    localparam int CNT_W      = 6;

    // Configuration register indexes.
    localparam logic [2:0] REG_BOX_X     = 3'd0;
    localparam logic [2:0] REG_BOX_Y     = 3'd1;
    localparam logic [2:0] REG_BOX_Z     = 3'd2;
    localparam logic [2:0] REG_BIN_WIDTH = 3'd3;
    localparam logic [2:0] REG_BINS_USED = 3'd4;

    // Item actions. The remaining code is ignored by the block.
    localparam logic [1:0] ACT_CLEAR   = 2'd0;
    localparam logic [1:0] ACT_ACCUM   = 2'd1;
    localparam logic [1:0] ACT_READ    = 2'd2;
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  bin_index;
        logic [31:0] bin_count;
        logic        last_bin;
    } t_out_item;

    typedef struct packed {
        logic [30:0]       box_x;
        logic [30:0]       box_y;
        logic [30:0]       box_z;
        logic [30:0]       bin_width;
        logic [USED_W-1:0] bins_used;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD_INIT,
        S_MOD_STEP,
        S_MINIMG,
        S_SQUARE,
        S_ACCUM,
        S_SQRT_INIT,
        S_SQRT_STEP,
        S_BIN_INIT,
        S_BIN_STEP,
        S_BIN_CHECK,
        S_MEM_WR,
        S_RD_FETCH,
        S_RD_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_MOD_INIT,
        OP_DIV_STEP,
        OP_MINIMG,
        OP_SQUARE,
        OP_ACCUM,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_BIN_INIT,
        OP_MEM_RD,
        OP_MEM_WR,
        OP_RD_FETCH,
        OP_RD_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op               op;
        logic [1:0]           axis;
        logic [BIN_IDX_W-1:0] idx;
        logic                 last;
    } t_dp_cmd;

    typedef struct packed {
        logic              out_full;
        logic              bin_hit;
        logic [USED_W-1:0] used;
    } t_dp_sts;

endpackage

// ===== rtl/pbc_pair_distance_histogram.sv =====
// Pair distance histogram with periodic boundaries. An accumulate item runs,
// per axis, a modulo by the box length on a shared restoring divider (33
// steps) and then minimum image, square and sum; then a 32-step square root,
// a 33-step division by the bin width and, for a bin in use, a read-modify-write
// of the bin memory; the divider does most of the work. A read fetches each
// bin in use and loads it into the result register, waiting while the result
// side stalls. Depends on pdh_pkg, pdh_regs, pdh_ctrl, pdh_dpath.
module pbc_pair_distance_histogram (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pdh_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pdh_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    pdh_pkg::t_cfg    w_cfg;
    pdh_pkg::t_dp_cmd w_cmd;
    pdh_pkg::t_dp_sts w_sts;

    // Configuration registers.
    pdh_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer.
    pdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, bin memory and result register.
    pdh_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (i_in_data),
        .i_cfg       (w_cfg),
        .i_out_ready (i_out_ready),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/pdh_regs.sv =====
// Configuration register file with an APB-style access port.
// Depends on pdh_pkg for the register indexes and the configuration struct.
module pdh_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output pdh_pkg::t_cfg     o_cfg
);

    pdh_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; values are masked to the register width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_x     <= 31'd4194304;
            r_cfg.box_y     <= 31'd4194304;
            r_cfg.box_z     <= 31'd4194304;
            r_cfg.bin_width <= 31'd65536;
            r_cfg.bins_used <= 7'd64;
        end else if (w_wr) begin
            unique case (w_idx)
                pdh_pkg::REG_BOX_X:     r_cfg.box_x     <= pwdata[30:0];
                pdh_pkg::REG_BOX_Y:     r_cfg.box_y     <= pwdata[30:0];
                pdh_pkg::REG_BOX_Z:     r_cfg.box_z     <= pwdata[30:0];
                pdh_pkg::REG_BIN_WIDTH: r_cfg.bin_width <= pwdata[30:0];
                pdh_pkg::REG_BINS_USED: r_cfg.bins_used <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // Read data.
    always_comb begin
        unique case (w_idx)
            pdh_pkg::REG_BOX_X:     prdata = {1'b0, r_cfg.box_x};
            pdh_pkg::REG_BOX_Y:     prdata = {1'b0, r_cfg.box_y};
            pdh_pkg::REG_BOX_Z:     prdata = {1'b0, r_cfg.box_z};
            pdh_pkg::REG_BIN_WIDTH: prdata = {1'b0, r_cfg.bin_width};
            pdh_pkg::REG_BINS_USED: prdata = {25'd0, r_cfg.bins_used};
            default:                prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/pdh_dpath.sv =====
// Datapath: shared restoring divider, squarer, square root unit, bin memory
// and result register. Depends on pdh_pkg for command, status and payload types.
module pdh_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pdh_pkg::t_dp_cmd     i_cmd,
    input  pdh_pkg::t_in_item    i_in_data,
    input  pdh_pkg::t_cfg        i_cfg,
    input  logic                 i_out_ready,
    output pdh_pkg::t_dp_sts     o_sts,
    output logic                 o_out_valid,
    output pdh_pkg::t_out_item   o_out_data
);

    localparam logic [pdh_pkg::COUNT_WIDTH-1:0] CountMax = '1;

    pdh_pkg::t_in_item  r_in;
    logic [30:0]        r_rem;
    logic [32:0]        r_quo;
    logic [30:0]        r_dvs;
    logic [29:0]        r_m;
    logic [59:0]        r_prod;
    logic [61:0]        r_sum;
    logic [63:0]        r_v;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [pdh_pkg::COUNT_WIDTH-1:0] r_rdata;
    logic               r_rvld;
    logic [pdh_pkg::NUM_BINS-1:0]    r_vld;
    logic               r_ovalid;
    pdh_pkg::t_out_item r_out;
    logic [pdh_pkg::COUNT_WIDTH-1:0] mem [pdh_pkg::NUM_BINS];

    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic [30:0]        w_box;
    logic signed [32:0] w_diff;
    logic [32:0]        w_abs;
    logic [31:0]        w_t;
    logic [31:0]        w_tsub;
    logic               w_ge;
    logic [30:0]        w_other;
    logic [63:0]        w_trial;
    logic [pdh_pkg::BIN_IDX_W-1:0] w_addr;
    logic [pdh_pkg::COUNT_WIDTH-1:0] w_cnt;
    logic [pdh_pkg::USED_W-1:0]      w_used;
    logic               w_load_out;

    // Axis selection for the minimum-image stage.
    always_comb begin
        unique case (i_cmd.axis)
            2'd0:    begin w_a = r_in.a_x; w_b = r_in.b_x; w_box = i_cfg.box_x; end
            2'd1:    begin w_a = r_in.a_y; w_b = r_in.b_y; w_box = i_cfg.box_y; end
            default: begin w_a = r_in.a_z; w_b = r_in.b_z; w_box = i_cfg.box_z; end
        endcase
    end

    assign w_diff = {w_a[31], w_a} - {w_b[31], w_b};
    assign w_abs  = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);

    // One restoring division step.
    assign w_t    = {r_rem, r_quo[32]};
    assign w_ge   = w_t >= {1'b0, r_dvs};
    assign w_tsub = w_t - {1'b0, r_dvs};

    assign w_other = r_dvs - r_rem;
    assign w_trial = r_res + r_bit;

    // Bins in use, limited to the histogram depth.
    assign w_used = (i_cfg.bins_used > pdh_pkg::USED_W'(pdh_pkg::NUM_BINS))
                  ? pdh_pkg::USED_W'(pdh_pkg::NUM_BINS) : i_cfg.bins_used;

    assign w_addr = (i_cmd.op == pdh_pkg::OP_RD_FETCH) ? i_cmd.idx
                  : r_quo[pdh_pkg::BIN_IDX_W-1:0];
    assign w_cnt  = r_rvld ? r_rdata : '0;

    assign w_load_out = (i_cmd.op == pdh_pkg::OP_RD_OUT);

    // Arithmetic registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            pdh_pkg::OP_LOAD: begin
                r_in  <= i_in_data;
                r_sum <= '0;
            end
            pdh_pkg::OP_MOD_INIT: begin
                r_quo <= w_abs;
                r_rem <= '0;
                r_dvs <= (w_box == '0) ? 31'd1 : w_box;
            end
            pdh_pkg::OP_DIV_STEP: begin
                r_rem <= w_ge ? w_tsub[30:0] : w_t[30:0];
                r_quo <= {r_quo[31:0], w_ge};
            end
            pdh_pkg::OP_MINIMG: begin
                r_m <= (r_rem < w_other) ? r_rem[29:0] : w_other[29:0];
            end
            pdh_pkg::OP_SQUARE: begin
                r_prod <= r_m * r_m;
            end
            pdh_pkg::OP_ACCUM: begin
                r_sum <= r_sum + {2'b00, r_prod};
            end
            pdh_pkg::OP_SQRT_INIT: begin
                r_v   <= {2'b00, r_sum};
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            pdh_pkg::OP_SQRT_STEP: begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            pdh_pkg::OP_BIN_INIT: begin
                r_quo <= {2'b00, r_res[30:0]};
                r_rem <= '0;
                r_dvs <= (i_cfg.bin_width == '0) ? 31'd1 : i_cfg.bin_width;
            end
            default: ;
        endcase
    end

    // Bin memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pdh_pkg::OP_MEM_RD || i_cmd.op == pdh_pkg::OP_RD_FETCH) begin
            r_rdata <= mem[w_addr];
            r_rvld  <= r_vld[w_addr];
        end
        if (i_cmd.op == pdh_pkg::OP_MEM_WR) begin
            mem[w_addr] <= (w_cnt == CountMax) ? w_cnt : w_cnt + 1'b1;
        end
    end

    // Per-bin valid flags: a bin not written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == pdh_pkg::OP_CLEAR) begin
            r_vld <= '0;
        end else if (i_cmd.op == pdh_pkg::OP_MEM_WR) begin
            r_vld[w_addr] <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out.bin_index <= i_cmd.idx;
            r_out.bin_count <= w_cnt[31:0];
            r_out.last_bin  <= i_cmd.last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_out;
    assign o_sts.out_full = r_ovalid && !i_out_ready;
    assign o_sts.bin_hit  = r_quo < {26'd0, w_used};
    assign o_sts.used     = w_used;

    // A count is written only into a bin that is in use.
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == pdh_pkg::OP_MEM_WR |-> r_quo < {26'd0, w_used})
        else $error("bin write outside the bins in use");

    // The result register is loaded only when it is free or being emptied.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> !(r_ovalid && !i_out_ready))
        else $error("result register overwritten");

    // The last result of a readout carries the highest bin in use.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.last_bin) |->
            {1'b0, r_out.bin_index} == pdh_pkg::USED_W'(w_used - 1'b1))
        else $error("last bin flag on wrong index");

endmodule

// ===== rtl/pdh_ctrl.sv =====
// Controller state machine: sequences the datapath through modulo, square,
// square root, binning, bin update and readout. Depends on pdh_pkg.
module pdh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_action,
    input  pdh_pkg::t_dp_sts  i_sts,
    output logic              o_in_ready,
    output pdh_pkg::t_dp_cmd  o_cmd
);

    pdh_pkg::t_state r_state, n_state;
    logic [pdh_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [1:0]                    r_axis, n_axis;
    logic [pdh_pkg::BIN_IDX_W-1:0] r_idx, n_idx;
    logic                          w_acc;
    logic                          w_last;

    assign o_in_ready = (r_state == pdh_pkg::S_IDLE);
    assign w_acc      = o_in_ready && i_in_valid;
    assign w_last     = {1'b0, r_idx} == pdh_pkg::USED_W'(i_sts.used - 1'b1);

    // State and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdh_pkg::S_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_idx   <= n_idx;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_axis     = r_axis;
        n_idx      = r_idx;
        o_cmd.op   = pdh_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        o_cmd.idx  = r_idx;
        o_cmd.last = w_last;
        unique case (r_state)
            pdh_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (i_action == pdh_pkg::ACT_CLEAR) begin
                        o_cmd.op = pdh_pkg::OP_CLEAR;
                    end else if (i_action == pdh_pkg::ACT_ACCUM) begin
                        o_cmd.op = pdh_pkg::OP_LOAD;
                        n_axis   = 2'd0;
                        n_state  = pdh_pkg::S_MOD_INIT;
                    end else if (i_action == pdh_pkg::ACT_READ
                                 && i_sts.used != '0) begin
                        n_idx   = '0;
                        n_state = pdh_pkg::S_RD_FETCH;
                    end
                end
            end
            pdh_pkg::S_MOD_INIT: begin
                o_cmd.op = pdh_pkg::OP_MOD_INIT;
                n_cnt    = '0;
                n_state  = pdh_pkg::S_MOD_STEP;
            end
            pdh_pkg::S_MOD_STEP: begin
                o_cmd.op = pdh_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == pdh_pkg::CNT_W'(pdh_pkg::DIV_STEPS - 1)) begin
                    n_state = pdh_pkg::S_MINIMG;
                end
            end
            pdh_pkg::S_MINIMG: begin
                o_cmd.op = pdh_pkg::OP_MINIMG;
                n_state  = pdh_pkg::S_SQUARE;
            end
            pdh_pkg::S_SQUARE: begin
                o_cmd.op = pdh_pkg::OP_SQUARE;
                n_state  = pdh_pkg::S_ACCUM;
            end
            pdh_pkg::S_ACCUM: begin
                o_cmd.op = pdh_pkg::OP_ACCUM;
                if (r_axis == 2'd2) begin
                    n_state = pdh_pkg::S_SQRT_INIT;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = pdh_pkg::S_MOD_INIT;
                end
            end
            pdh_pkg::S_SQRT_INIT: begin
                o_cmd.op = pdh_pkg::OP_SQRT_INIT;
                n_cnt    = '0;
                n_state  = pdh_pkg::S_SQRT_STEP;
            end
            pdh_pkg::S_SQRT_STEP: begin
                o_cmd.op = pdh_pkg::OP_SQRT_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == pdh_pkg::CNT_W'(pdh_pkg::SQRT_STEPS - 1)) begin
                    n_state = pdh_pkg::S_BIN_INIT;
                end
            end
            pdh_pkg::S_BIN_INIT: begin
                o_cmd.op = pdh_pkg::OP_BIN_INIT;
                n_cnt    = '0;
                n_state  = pdh_pkg::S_BIN_STEP;
            end
            pdh_pkg::S_BIN_STEP: begin
                o_cmd.op = pdh_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == pdh_pkg::CNT_W'(pdh_pkg::DIV_STEPS - 1)) begin
                    n_state = pdh_pkg::S_BIN_CHECK;
                end
            end
            pdh_pkg::S_BIN_CHECK: begin
                if (i_sts.bin_hit) begin
                    o_cmd.op = pdh_pkg::OP_MEM_RD;
                    n_state  = pdh_pkg::S_MEM_WR;
                end else begin
                    n_state = pdh_pkg::S_IDLE;
                end
            end
            pdh_pkg::S_MEM_WR: begin
                o_cmd.op = pdh_pkg::OP_MEM_WR;
                n_state  = pdh_pkg::S_IDLE;
            end
            pdh_pkg::S_RD_FETCH: begin
                o_cmd.op = pdh_pkg::OP_RD_FETCH;
                n_state  = pdh_pkg::S_RD_OUT;
            end
            pdh_pkg::S_RD_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.op = pdh_pkg::OP_RD_OUT;
                    if (w_last) begin
                        n_state = pdh_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = pdh_pkg::S_RD_FETCH;
                    end
                end
            end
            default: n_state = pdh_pkg::S_IDLE;
        endcase
    end

    // Step counter stays within the longest iteration.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pdh_pkg::S_MOD_STEP || r_state == pdh_pkg::S_BIN_STEP)
            |-> r_cnt < pdh_pkg::CNT_W'(pdh_pkg::DIV_STEPS))
        else $error("division step counter overrun");

    // Readout never walks past the bins in use.
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pdh_pkg::S_RD_OUT |-> {1'b0, r_idx} < i_sts.used)
        else $error("readout index beyond bins in use");

    // A bin update always follows a successful bin check.
    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pdh_pkg::S_MEM_WR |-> $past(r_state) == pdh_pkg::S_BIN_CHECK)
        else $error("bin write without bin check");

endmodule
